>>> hw/rtl/hfc_pkg.sv
package hfc_pkg;
	localparam logic OP_TO_HALF   = 1'b0;
	localparam logic OP_TO_SINGLE = 1'b1;
	localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;
	localparam logic [7:0] EXP_OVF       = 8'd143;
	localparam logic [7:0] EXP_UNF       = 8'd102;
	localparam logic [15:0] HALF_INF     = 16'h7C00;
	localparam logic [15:0] HALF_QNAN    = 16'h7E00;

	// stage 1 -> stage 2 decode for narrowing, plus the half input for widening
	typedef struct packed {
		logic        op;
		logic        sign;
		logic        special;      // result fixed: inf, nan, zero
		logic [15:0] fixed_val;
		logic        sub;          // half subnormal path
		logic [4:0]  sh;           // subnormal shift 14..24
		logic [7:0]  ex;
		logic [23:0] man;          // with hidden bit for subnormal path
		logic [15:0] hv;           // half input for widening
	} dec_t;
endpackage

>>> hw/rtl/half_float_converter.sv
// channel | dir | ports                        | handshake
// request | in  | start, operation, value_bits | start && !busy
// result  | out | done, result_bits            | done strobe, one cycle
// One item per cycle; each result passes through the decode, shift/round and
// pack stages, each registered. busy stays low: the pipeline never
// stalls because the receiver cannot hold results off.
// arst_n clears the stage valid bits only; payload registers are not reset.
module half_float_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] value_bits,
	output logic        done,
	output logic [31:0] result_bits
);
	import hfc_pkg::*;

	logic v_s1, v_s2, v_s3;
	dec_t d_s1;
	logic        op_s2, sign_s2, spec_s2;
	logic [15:0] fixed_s2, h_s2, hv_s2;
	logic        rup_s2;
	logic [31:0] res_s3;
	logic        op_s3;

	assign busy = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: classify
	dec_t dec_c;
	always_comb begin
		logic [7:0] ex;
		ex = value_bits[30:23];
		dec_c = '0;
		dec_c.op = operation;
		dec_c.sign = value_bits[31];
		dec_c.ex = ex;
		dec_c.hv = value_bits[15:0];
		dec_c.man = {1'b0, value_bits[22:0]};
		if (ex == 8'hFF) begin
			dec_c.special = 1'b1;
			dec_c.fixed_val = (value_bits[22:0] != '0) ? HALF_QNAN : HALF_INF;
		end else if (ex >= EXP_OVF) begin
			dec_c.special = 1'b1;
			dec_c.fixed_val = HALF_INF;
		end else if (ex < EXP_UNF) begin
			dec_c.special = 1'b1;
			dec_c.fixed_val = '0;
		end else if (ex <= EXP_BIAS_DIFF) begin
			dec_c.sub = 1'b1;
			dec_c.man = {1'b1, value_bits[22:0]};
			dec_c.sh = 5'(8'd126 - ex);
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= dec_c;
	end

	// stage 2: shift and round decision
	logic        rup_s2_c;
	logic [15:0] h_c;
	always_comb begin
		logic [23:0] h, rest, mid, mask;
		if (d_s1.sub) begin
			h = d_s1.man >> d_s1.sh;
			mask = (24'd1 << d_s1.sh) - 24'd1;
			rest = d_s1.man & mask;
			mid = 24'd1 << (d_s1.sh - 5'd1);
		end else begin
			h = {9'd0, 5'(d_s1.ex - EXP_BIAS_DIFF), d_s1.man[22:13]};
			mask = '0;
			rest = {11'd0, d_s1.man[12:0]};
			mid = 24'h1000;
		end
		rup_s2_c = (rest > mid) || (rest == mid && h[0]);
		h_c = h[15:0];
	end

	always_ff @(posedge clk) begin
		op_s2    <= d_s1.op;
		sign_s2  <= d_s1.sign;
		spec_s2  <= d_s1.special;
		fixed_s2 <= d_s1.fixed_val;
		h_s2     <= h_c;
		rup_s2   <= rup_s2_c;
		hv_s2    <= d_s1.hv;
	end

	// stage 3: increment, pack, widen
	logic [31:0] res_c;
	always_comb begin
		logic [15:0] hr;
		logic [9:0]  m;
		logic [3:0]  k;
		logic [31:0] wide;
		hr = {sign_s2, 15'd0} | (spec_s2 ? fixed_s2 : (h_s2 + 16'(rup_s2)));
		m = hv_s2[9:0];
		k = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (m[i] && k == 4'd0) k = 4'(10 - i);
		end
		if (hv_s2[14:10] == 5'd0) begin
			if (m == '0) wide = {hv_s2[15], 31'd0};
			else wide = {hv_s2[15], 8'(8'd113 - {4'd0, k}), 10'(m << k), 13'd0};
		end else if (hv_s2[14:10] == 5'h1F) begin
			wide = {hv_s2[15], 8'hFF, m, 13'd0};
		end else begin
			wide = {hv_s2[15], 8'({3'd0, hv_s2[14:10]} + 8'd112), m, 13'd0};
		end
		res_c = (op_s2 == OP_TO_SINGLE) ? wide : {16'd0, hr};
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_c;
		op_s3  <= op_s2;
	end

	assign done = v_s3;
	assign result_bits = res_s3;

`ifndef ASSERT_OFF
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("result latency broken");
	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##3 !done) else $error("spurious result");
	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !op_s3) |-> result_bits[31:16] == 16'd0)
		else $error("half result upper bits set");
`endif
endmodule

>>> bench/tb_half_float_converter.sv
module tb_half_float_converter;
	import hfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 750;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        operation;
	logic [31:0] value_bits;
	logic        done;
	logic [31:0] result_bits;

	half_float_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value_bits(value_bits),
		.done(done),
		.result_bits(result_bits)
	);

	// directed request with an optional typed-in expectation
	typedef struct {
		logic        op;
		logic [31:0] val;
		logic        has_known;
		logic [31:0] known;
	} dir_row_t;

	logic [31:0] pending_results[$];
	int mismatches = 0;
	int unexpected = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int narrow_cnt = 0;
	int widen_cnt = 0;
	int idle_cnt = 0;
	int sender_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// narrowing: single to half, round to nearest even
	function automatic logic [31:0] single_to_half(logic [31:0] u);
		logic [15:0] sgn;
		logic [7:0]  ex;
		logic [23:0] man;
		logic [31:0] h;
		logic [31:0] rest;
		logic [31:0] mid;
		int          sh;
		sgn = {u[31], 15'd0};
		ex = u[30:23];
		man = {1'b0, u[22:0]};
		if (ex == 8'hFF)
			return {16'd0, sgn | HALF_INF | (man != 0 ? 16'h0200 : 16'h0000)};
		if (ex >= EXP_OVF)
			return {16'd0, sgn | HALF_INF};
		if (ex <= EXP_BIAS_DIFF) begin
			if (int'(ex) + 10 < int'(EXP_BIAS_DIFF))
				return {16'd0, sgn};
			man[23] = 1'b1;
			sh = 126 - int'(ex);
			h = 32'(man) >> sh;
			rest = 32'(man) & ((32'd1 << sh) - 1);
			mid = 32'd1 << (sh - 1);
			if (rest > mid || (rest == mid && h[0]))
				h = h + 1;
			return {16'd0, sgn | h[15:0]};
		end
		h = {16'd0, sgn} | (32'(ex - EXP_BIAS_DIFF) << 10) | 32'(man[22:13]);
		rest = 32'(man[12:0]);
		mid = 32'h1000;
		if (rest > mid || (rest == mid && h[0]))
			h = h + 1;
		return h & 32'hFFFF;
	endfunction

	// widening: half to single, exact
	function automatic logic [31:0] half_to_single(logic [15:0] hv);
		logic [4:0]  ex;
		logic [10:0] man;
		int          k;
		ex = hv[14:10];
		man = {1'b0, hv[9:0]};
		k = 0;
		if (ex == 5'd0) begin
			if (man == 0)
				return {hv[15], 31'd0};
			while (!man[10] && k < 11) begin
				man = man << 1;
				k++;
			end
			return {hv[15], 8'(113 - k), man[9:0], 13'd0};
		end
		if (ex == 5'h1F)
			return {hv[15], 8'hFF, hv[9:0], 13'd0};
		return {hv[15], 8'(int'(ex) + 112), hv[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] convert_pattern(logic op, logic [31:0] v);
		if (op == OP_TO_HALF)
			return single_to_half(v);
		return half_to_single(v[15:0]);
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (done) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					unexpected++;
					$display("unexpected result %h", result_bits);
				end else begin
					want = pending_results.pop_front();
					if (result_bits !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: result_bits expected %h got %h",
								want, result_bits);
					end
				end
			end
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("watchdog expired, %0d results pending",
					pending_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// hold one request until accepted; gap cycles before it per current phase
	task automatic send_request(logic op, logic [31:0] v, logic has_known,
		logic [31:0] known);
		logic [31:0] want;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		value_bits <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		want = has_known ? known : convert_pattern(op, v);
		pending_results.push_back(want);
		requests_sent++;
		if (op == OP_TO_HALF)
			narrow_cnt++;
		else
			widen_cnt++;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// random operand biased toward interesting exponents and rounding ties
	function automatic logic [31:0] rand_operand(logic op);
		logic [31:0] v;
		v = $urandom;
		if (op == OP_TO_HALF) begin
			case ($urandom_range(5))
				0: v[30:23] = 8'(EXP_UNF + $urandom_range(12));
				1: v[30:23] = 8'(EXP_BIAS_DIFF + $urandom_range(31));
				2: v[30:23] = 8'(EXP_OVF - 1 + $urandom_range(1));
				3: v[12:0] = {1'b1, 12'd0};
				4: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
				default: ;
			endcase
		end else begin
			case ($urandom_range(3))
				0: v[14:10] = 5'd0;
				1: v[14:10] = 5'h1F;
				default: ;
			endcase
		end
		return v;
	endfunction

	dir_row_t dir_rows[] = '{
		'{OP_TO_HALF, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_TO_HALF, 32'h8000_0000, 1'b1, 32'h0000_8000},
		'{OP_TO_HALF, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
		'{OP_TO_HALF, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
		'{OP_TO_HALF, 32'h7FFF_FFFF, 1'b1, 32'h0000_7E00},
		'{OP_TO_HALF, 32'hFF80_0001, 1'b1, 32'h0000_FE00},
		'{OP_TO_HALF, 32'h4780_0000, 1'b1, 32'h0000_7C00},
		'{OP_TO_HALF, 32'h477F_F000, 1'b1, 32'h0000_7C00},
		'{OP_TO_HALF, 32'h477F_E000, 1'b1, 32'h0000_7BFF},
		'{OP_TO_HALF, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
		'{OP_TO_HALF, 32'h3F80_1000, 1'b0, 32'h0},
		'{OP_TO_HALF, 32'h3F80_3000, 1'b0, 32'h0},
		'{OP_TO_HALF, 32'h0000_0001, 1'b1, 32'h0000_0000},
		'{OP_TO_HALF, 32'h3300_0000, 1'b0, 32'h0},
		'{OP_TO_HALF, 32'h3300_0001, 1'b0, 32'h0},
		'{OP_TO_HALF, 32'h387F_FFFF, 1'b0, 32'h0},
		'{OP_TO_HALF, 32'hB2FF_FFFF, 1'b0, 32'h0},
		'{OP_TO_SINGLE, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_TO_SINGLE, 32'hFFFF_8000, 1'b1, 32'h8000_0000},
		'{OP_TO_SINGLE, 32'h0000_0001, 1'b1, 32'h3380_0000},
		'{OP_TO_SINGLE, 32'h0000_03FF, 1'b0, 32'h0},
		'{OP_TO_SINGLE, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
		'{OP_TO_SINGLE, 32'hABCD_FDFF, 1'b1, 32'hFFBF_E000},
		'{OP_TO_SINGLE, 32'h0000_7BFF, 1'b1, 32'h477F_E000},
		'{OP_TO_SINGLE, 32'h1234_3C00, 1'b1, 32'h3F80_0000}
	};

	// stimulus
	initial begin
		int    phase_pct[4] = '{0, 57, 0, 11};
		logic  op;
		arst_n = 1'b0;
		start = 1'b0;
		operation = 1'b0;
		value_bits = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].has_known,
				dir_rows[i].known);
		start <= 1'b0;
		// sender holds off until everything directed has come back
		wait_drained();
		@(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sender_idle_pct = phase_pct[(i * 4) / RANDOM_ITEMS];
			op = 1'($urandom_range(1));
			send_request(op, rand_operand(op), 1'b0, 32'h0);
		end
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d narrowing, %0d widening), %0d results checked",
			requests_sent, narrow_cnt, widen_cnt, results_seen);
		$display("covered signed zeros, infinities, NaNs, subnormals, rounding carries");
		if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/hfc_pkg.sv
hw/rtl/half_float_converter.sv
bench/tb_half_float_converter.sv
